@@ src/v3alu_pkg.sv @@
// ----------------------------------------------------------------------------
// v3alu_pkg
// Shared types, codes and saturation helpers for the vector ALU.
// ----------------------------------------------------------------------------
package v3alu_pkg;

  // Operation codes
  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_MUL   = 3'd2,
    CMD_DIV   = 3'd3,
    CMD_SCALE = 3'd4,
    CMD_MAG   = 3'd5,
    CMD_NORM  = 3'd6
  } cmd_e;

  localparam logic signed [31:0] MAX32 = 32'sh7fff_ffff;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

  // Pipeline depths of the iterative units
  localparam int unsigned SQRT_LAT = 32;
  localparam int unsigned DIV_LAT  = 33;

  // Input item
  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scale_factor;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic               overflow_flag;
    logic               divide_zero_flag;
  } out_item_t;

  // Saturated value with its overflow note
  typedef struct packed {
    logic signed [31:0] val;
    logic               ovf;
  } sat_t;

  // Per-lane state leaving the lane front end
  typedef struct packed {
    logic signed [31:0] res;    // add/sub/mul/scale result
    logic               ovf;
    logic               dz;     // b component is zero
    logic               a_neg;
    logic               q_neg;  // sign of the quotient
    logic [63:0]        num;    // quotient numerator magnitude
    logic [31:0]        den;    // element divisor magnitude
  } lane_mid_t;

  // Per-lane state carried alongside the divider
  typedef struct packed {
    logic signed [31:0] res;
    logic               ovf;
    logic               dz;
    logic               a_neg;
    logic               q_neg;
  } lane_fin_t;

  typedef struct packed {
    cmd_e                  cmd;
    lane_mid_t [2:0]       ln;
  } side_a_t;

  typedef struct packed {
    cmd_e                  cmd;
    lane_fin_t [2:0]       ln;
  } side_b_t;

  // Clamp a 64-bit signed value to 32 bits
  function automatic sat_t sat64(input logic signed [63:0] v);
    sat_t s;
    if (v > 64'sh0000_0000_7fff_ffff) begin
      s.val = MAX32;
      s.ovf = 1'b1;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      s.val = MIN32;
      s.ovf = 1'b1;
    end else begin
      s.val = v[31:0];
      s.ovf = 1'b0;
    end
    return s;
  endfunction

  // Apply sign and clamp to a quotient magnitude; big means >= 2^32
  function automatic sat_t quot_sat(input logic [31:0] q, input logic big,
                                    input logic neg);
    sat_t s;
    if (!neg) begin
      if (big || q[31]) begin
        s.val = MAX32;
        s.ovf = 1'b1;
      end else begin
        s.val = q;
        s.ovf = 1'b0;
      end
    end else begin
      if (big || (q > 32'h8000_0000)) begin
        s.val = MIN32;
        s.ovf = 1'b1;
      end else begin
        s.val = ~q + 32'd1;
        s.ovf = 1'b0;
      end
    end
    return s;
  endfunction

endpackage

@@ src/v3alu_lane.sv @@
// ----------------------------------------------------------------------------
// v3alu_lane
// Front end of one vector component: multiply, add/sub, saturation and
// preparation of the divider operands. Two register stages.
// ----------------------------------------------------------------------------
module v3alu_lane import v3alu_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  cmd_e               cmd_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic signed [31:0] m_i,
  output lane_mid_t          mid_o,
  output logic [63:0]        sq_o
);

  // Stage 1 signals
  logic signed [31:0] mul_y;
  logic signed [63:0] prod_d, prod_q;
  logic signed [32:0] addsub_d, addsub_q;
  logic [31:0]        abs_a_d, abs_a_q, abs_b_d, abs_b_q, abs_m_d, abs_m_q;
  logic               a_neg_q, b_neg_q, m_neg_q, b_zero_q;
  cmd_e               cmd_q;

  // Stage 2 signals
  lane_mid_t   mid_d, mid_q;
  logic [63:0] sq_d, sq_q;
  sat_t        sat_as, sat_pr;

  // Multiplier operand select
  always_comb begin
    case (cmd_i)
      CMD_MUL:   mul_y = b_i;
      CMD_SCALE: mul_y = m_i;
      default:   mul_y = a_i;
    endcase
  end

  assign prod_d   = a_i * mul_y;
  assign addsub_d = (cmd_i == CMD_SUB) ? ({a_i[31], a_i} - {b_i[31], b_i})
                                       : ({a_i[31], a_i} + {b_i[31], b_i});
  assign abs_a_d  = a_i[31] ? (~a_i + 32'd1) : a_i;
  assign abs_b_d  = b_i[31] ? (~b_i + 32'd1) : b_i;
  assign abs_m_d  = m_i[31] ? (~m_i + 32'd1) : m_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd_q    <= cmd_i;
      prod_q   <= prod_d;
      addsub_q <= addsub_d;
      abs_a_q  <= abs_a_d;
      abs_b_q  <= abs_b_d;
      abs_m_q  <= abs_m_d;
      a_neg_q  <= a_i[31];
      b_neg_q  <= b_i[31];
      m_neg_q  <= m_i[31];
      b_zero_q <= (b_i == 32'sd0);
    end
  end

  // Stage 2: saturate simple results, build divider operands
  assign sat_as = sat64({{31{addsub_q[32]}}, addsub_q});
  assign sat_pr = sat64(prod_q >>> FRAC_BITS);

  always_comb begin
    mid_d       = '0;
    mid_d.dz    = b_zero_q;
    mid_d.a_neg = a_neg_q;
    sq_d        = '0;
    case (cmd_q)
      CMD_ADD, CMD_SUB: begin
        mid_d.res = sat_as.val;
        mid_d.ovf = sat_as.ovf;
      end
      CMD_MUL, CMD_SCALE: begin
        mid_d.res = sat_pr.val;
        mid_d.ovf = sat_pr.ovf;
      end
      CMD_DIV: begin
        mid_d.num   = {32'd0, abs_a_q} << FRAC_BITS;
        mid_d.den   = abs_b_q;
        mid_d.q_neg = a_neg_q ^ b_neg_q;
      end
      CMD_MAG: begin
        sq_d = prod_q;
      end
      CMD_NORM: begin
        sq_d        = prod_q;
        mid_d.num   = abs_m_q * abs_a_q;
        mid_d.q_neg = a_neg_q ^ m_neg_q;
      end
      default: begin
        mid_d.res = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= mid_d;
      sq_q  <= sq_d;
    end
  end

  assign mid_o = mid_q;
  assign sq_o  = sq_q;

endmodule

@@ src/v3alu_sqrt.sv @@
// ----------------------------------------------------------------------------
// v3alu_sqrt
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module v3alu_sqrt import v3alu_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] x_i,
  output logic [31:0] root_o
);

  logic [63:0] x_q [SQRT_LAT];
  logic [63:0] r_q [SQRT_LAT];
  logic [63:0] x_d [SQRT_LAT];
  logic [63:0] r_d [SQRT_LAT];

  // One digit step per stage; the trial bit walks down two places a stage
  always_comb begin
    logic [63:0] xin, rin, bitv, trial;
    for (int k = 0; k < SQRT_LAT; k++) begin
      xin   = (k == 0) ? x_i : x_q[(k == 0) ? 0 : k - 1];
      rin   = (k == 0) ? 64'd0 : r_q[(k == 0) ? 0 : k - 1];
      bitv  = 64'd1 << (62 - 2 * k);
      trial = rin + bitv;
      if (xin >= trial) begin
        x_d[k] = xin - trial;
        r_d[k] = (rin >> 1) + bitv;
      end else begin
        x_d[k] = xin;
        r_d[k] = rin >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SQRT_LAT; k++) begin
        x_q[k] <= x_d[k];
        r_q[k] <= r_d[k];
      end
    end
  end

  assign root_o = r_q[SQRT_LAT-1][31:0];

endmodule

@@ src/v3alu_div.sv @@
// ----------------------------------------------------------------------------
// v3alu_div
// Pipelined unsigned divider: 64-bit numerator by 32-bit divisor. A range
// check flags quotients of 2^32 or more, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module v3alu_div import v3alu_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic [31:0] quot_o,
  output logic        big_o
);

  logic [63:0] rem_q [DIV_LAT];
  logic [31:0] den_q [DIV_LAT];
  logic [31:0] quo_q [DIV_LAT];
  logic        big_q [DIV_LAT];
  logic [63:0] rem_d [DIV_LAT];
  logic [31:0] quo_d [DIV_LAT];

  // Restoring steps, quotient bit 31 first
  always_comb begin
    logic [63:0] sh;
    rem_d[0] = num_i;
    quo_d[0] = '0;
    for (int s = 1; s < DIV_LAT; s++) begin
      sh       = {32'd0, den_q[s-1]} << (DIV_LAT - 1 - s);
      rem_d[s] = rem_q[s-1];
      quo_d[s] = quo_q[s-1];
      if (rem_q[s-1] >= sh) begin
        rem_d[s] = rem_q[s-1] - sh;
        quo_d[s][DIV_LAT-1-s] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_d[0];
      quo_q[0] <= quo_d[0];
      den_q[0] <= den_i;
      big_q[0] <= (num_i >= {den_i, 32'd0});
      for (int s = 1; s < DIV_LAT; s++) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        den_q[s] <= den_q[s-1];
        big_q[s] <= big_q[s-1];
      end
    end
  end

  assign quot_o = quo_q[DIV_LAT-1];
  assign big_o  = big_q[DIV_LAT-1];

endmodule

@@ src/vec3_alu_normalize_core.sv @@
// ----------------------------------------------------------------------------
// vec3_alu_normalize_core
// Three-component Q-format vector ALU with magnitude and normalize.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one in_item_t per item:
//   an operation code, vectors a and b and a scalar. Output channel
//   out_valid_o/out_ready_i returns one out_item_t per item, in order.
//   Path from acceptance to out_valid_o: 2 lane stages, one sum stage,
//   32 square-root stages, 33 divider stages and the output register.
//   Every item, whatever its operation, takes the same path.
//   Throughput: one item per cycle unless stalled; the 32-stage square root
//   and the 33-stage divider, past its range check, retire one bit per stage.
//   When the receiver stalls, the pipeline keeps filling its empty slots
//   and stops only once an item is waiting at the output register with a
//   full last stage behind it; in_ready_o then drops.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
// ----------------------------------------------------------------------------
module vec3_alu_normalize_core import v3alu_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned LAT = 3 + SQRT_LAT + DIV_LAT;

  logic             adv;
  logic [LAT-1:0]   v_q;
  logic             out_valid_q;
  out_item_t        out_q, out_d;

  cmd_e             cmd_in, cmd1_q, cmd2_q;
  lane_mid_t [2:0]  mid;
  logic [63:0]      sq [3];
  logic [63:0]      sum_q;
  side_a_t          side3_q;
  side_a_t          sa_q [SQRT_LAT];
  side_b_t          sb_d;
  side_b_t          sb_q [DIV_LAT];
  logic [31:0]      mag;
  logic [31:0]      den_n;
  logic [31:0]      quot [3];
  logic             big [3];
  sat_t             mag_sat;

  // Pipeline moves unless a finished item is blocked at the output and the last stage is full
  assign adv        = !out_valid_q || out_ready_i || !v_q[LAT-1];
  assign in_ready_o = adv;
  assign cmd_in     = cmd_e'(in_data_i.cmd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[LAT-2:0], in_valid_i};
    end
  end

  // Lanes
  v3alu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk_i(clk_i), .en_i(adv), .cmd_i(cmd_in), .a_i(in_data_i.a_x),
    .b_i(in_data_i.b_x), .m_i(in_data_i.scale_factor), .mid_o(mid[0]), .sq_o(sq[0])
  );
  v3alu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk_i(clk_i), .en_i(adv), .cmd_i(cmd_in), .a_i(in_data_i.a_y),
    .b_i(in_data_i.b_y), .m_i(in_data_i.scale_factor), .mid_o(mid[1]), .sq_o(sq[1])
  );
  v3alu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk_i(clk_i), .en_i(adv), .cmd_i(cmd_in), .a_i(in_data_i.a_z),
    .b_i(in_data_i.b_z), .m_i(in_data_i.scale_factor), .mid_o(mid[2]), .sq_o(sq[2])
  );

  // Command delay alongside the lanes, then sum of squares
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd1_q      <= cmd_in;
      cmd2_q      <= cmd1_q;
      sum_q       <= sq[0] + sq[1] + sq[2];
      side3_q.cmd <= cmd2_q;
      side3_q.ln  <= mid;
    end
  end

  v3alu_sqrt u_sqrt (
    .clk_i(clk_i), .en_i(adv), .x_i(sum_q), .root_o(mag)
  );

  // Side data delayed to line up with the root
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_q[0] <= side3_q;
      for (int k = 1; k < SQRT_LAT; k++) sa_q[k] <= sa_q[k-1];
    end
  end

  // Root exit: magnitude result and normalize divisor
  assign mag_sat = quot_sat(mag, 1'b0, 1'b0);
  assign den_n   = (mag == 32'd0) ? (32'd1 << FRAC_BITS) : mag;

  always_comb begin
    sb_d.cmd = sa_q[SQRT_LAT-1].cmd;
    for (int l = 0; l < 3; l++) begin
      sb_d.ln[l].res   = sa_q[SQRT_LAT-1].ln[l].res;
      sb_d.ln[l].ovf   = sa_q[SQRT_LAT-1].ln[l].ovf;
      sb_d.ln[l].dz    = sa_q[SQRT_LAT-1].ln[l].dz;
      sb_d.ln[l].a_neg = sa_q[SQRT_LAT-1].ln[l].a_neg;
      sb_d.ln[l].q_neg = sa_q[SQRT_LAT-1].ln[l].q_neg;
    end
    if (sb_d.cmd == CMD_MAG) begin
      sb_d.ln[0].res = mag_sat.val;
      sb_d.ln[0].ovf = mag_sat.ovf;
    end
  end

  // One divider per lane
  for (genvar l = 0; l < 3; l++) begin : g_div
    logic [31:0] den;
    assign den = (sa_q[SQRT_LAT-1].cmd == CMD_NORM) ? den_n : sa_q[SQRT_LAT-1].ln[l].den;
    v3alu_div u_div (
      .clk_i(clk_i), .en_i(adv), .num_i(sa_q[SQRT_LAT-1].ln[l].num), .den_i(den),
      .quot_o(quot[l]), .big_o(big[l])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_q[0] <= sb_d;
      for (int k = 1; k < DIV_LAT; k++) sb_q[k] <= sb_q[k-1];
    end
  end

  // Merge lanes into one result item
  always_comb begin
    logic signed [31:0] r [3];
    logic               ovf, dz;
    sat_t               qs;
    ovf = 1'b0;
    dz  = 1'b0;
    for (int l = 0; l < 3; l++) begin
      qs = quot_sat(quot[l], big[l], sb_q[DIV_LAT-1].ln[l].q_neg);
      case (sb_q[DIV_LAT-1].cmd)
        CMD_DIV: begin
          if (sb_q[DIV_LAT-1].ln[l].dz) begin
            r[l] = sb_q[DIV_LAT-1].ln[l].a_neg ? MIN32 : MAX32;
            dz   = 1'b1;
          end else begin
            r[l] = qs.val;
            ovf  = ovf | qs.ovf;
          end
        end
        CMD_NORM: begin
          r[l] = qs.val;
          ovf  = ovf | qs.ovf;
        end
        default: begin
          r[l] = sb_q[DIV_LAT-1].ln[l].res;
          ovf  = ovf | sb_q[DIV_LAT-1].ln[l].ovf;
        end
      endcase
    end
    out_d.r_x              = r[0];
    out_d.r_y              = r[1];
    out_d.r_z              = r[2];
    out_d.overflow_flag    = ovf;
    out_d.divide_zero_flag = dz;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && v_q[LAT-1]) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v_q[LAT-1]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
